### sv/sphere_frustum_cull_top_assert.svh
// Assertion macros shared by the culling block.
`ifndef SPHERE_FRUSTUM_CULL_TOP_ASSERT_SVH
`define SPHERE_FRUSTUM_CULL_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// a implies b in the same cycle
`define SFC_ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("sfc assertion failed: same-cycle implication");

// a implies b in the next cycle
`define SFC_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("sfc assertion failed: next-cycle implication");

`else

`define SFC_ASSERT_NOW(label, clk, rst_n, a, b)
`define SFC_ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

### sv/sfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfc_pkg;

    localparam int PLANE_COUNT = 6;
    localparam int FRAC_ALIGN  = 14;

    typedef logic signed [15:0] coord_t;
    typedef logic        [14:0] radius_t;
    typedef logic signed [15:0] normal_t;
    typedef logic signed [15:0] offset_t;
    typedef logic signed [33:0] dist_t;
    typedef logic signed [19:0] min_dist_t;
    typedef logic        [2:0]  cfg_index_t;
    typedef logic        [63:0] cfg_data_t;

    typedef struct packed {
        normal_t nx;
        normal_t ny;
        normal_t nz;
        offset_t d;
    } plane_t;

    typedef enum logic [2:0] {
        REG_PLANE_LEFT   = 3'd0,
        REG_PLANE_RIGHT  = 3'd1,
        REG_PLANE_BOTTOM = 3'd2,
        REG_PLANE_TOP    = 3'd3,
        REG_PLANE_NEAR   = 3'd4,
        REG_PLANE_FAR    = 3'd5
    } reg_index_t;

    // zero normal, d = +2047.9375: never culls
    localparam plane_t PLANE_RESET = plane_t'(64'd32767);

endpackage

`default_nettype wire

### sv/sfc_sphere_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sfc_sphere_if;
    import sfc_pkg::*;

    logic    valid;
    logic    ready;
    coord_t  center_x;
    coord_t  center_y;
    coord_t  center_z;
    radius_t sphere_radius;

    modport source (
        output valid, center_x, center_y, center_z, sphere_radius,
        input  ready
    );

    modport sink (
        input  valid, center_x, center_y, center_z, sphere_radius,
        output ready
    );
endinterface

`default_nettype wire

### sv/sfc_result_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sfc_result_if;
    import sfc_pkg::*;

    logic      valid;
    logic      ready;
    logic      visible;
    min_dist_t min_distance;

    modport source (
        output valid, visible, min_distance,
        input  ready
    );

    modport sink (
        input  valid, visible, min_distance,
        output ready
    );
endinterface

`default_nettype wire

### sv/sfc_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sfc_cfg_if;
    import sfc_pkg::*;

    logic       valid;
    logic       ready;
    cfg_index_t index;
    cfg_data_t  data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

### sv/sfc_plane_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module sfc_plane_regs (
    input  wire logic          clk,
    input  wire logic          rst_n,
    sfc_cfg_if.sink            cfg,
    output sfc_pkg::plane_t    planes [sfc_pkg::PLANE_COUNT]
);
    import sfc_pkg::*;

    plane_t planes_reg  [PLANE_COUNT];
    plane_t planes_next [PLANE_COUNT];

    assign cfg.ready = 1'b1;

    // decode the write; indexes past the far plane drop the word
    always_comb
    begin
        planes_next = planes_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_PLANE_LEFT:   planes_next[0] = plane_t'(cfg.data);
                REG_PLANE_RIGHT:  planes_next[1] = plane_t'(cfg.data);
                REG_PLANE_BOTTOM: planes_next[2] = plane_t'(cfg.data);
                REG_PLANE_TOP:    planes_next[3] = plane_t'(cfg.data);
                REG_PLANE_NEAR:   planes_next[4] = plane_t'(cfg.data);
                REG_PLANE_FAR:    planes_next[5] = plane_t'(cfg.data);
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PLANE_COUNT; i++)
            begin
                planes_reg[i] <= PLANE_RESET;
            end
        end
        else
        begin
            planes_reg <= planes_next;
        end
    end

    assign planes = planes_reg;

endmodule

`default_nettype wire

### sv/sfc_plane_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module sfc_plane_lane (
    input  wire sfc_pkg::plane_t  plane,
    input  wire sfc_pkg::coord_t  center_x,
    input  wire sfc_pkg::coord_t  center_y,
    input  wire sfc_pkg::coord_t  center_z,
    input  wire sfc_pkg::radius_t sphere_radius,
    output sfc_pkg::dist_t        plane_sum
);
    import sfc_pkg::*;

    logic signed [31:0] prod_x;
    logic signed [31:0] prod_y;
    logic signed [31:0] prod_z;
    dist_t              d_ext;
    dist_t              r_ext;
    dist_t              dr_aligned;

    // Q1.14 * Q12.4 products are exact in Q.18
    assign prod_x = plane.nx * center_x;
    assign prod_y = plane.ny * center_y;
    assign prod_z = plane.nz * center_z;

    // align d + r from Q.4 to Q.18; magnitude stays below 2^31
    assign d_ext      = dist_t'(plane.d);
    assign r_ext      = dist_t'($signed({1'b0, sphere_radius}));
    assign dr_aligned = (d_ext + r_ext) <<< FRAC_ALIGN;

    assign plane_sum = dist_t'(prod_x) + dist_t'(prod_y) + dist_t'(prod_z) + dr_aligned;

endmodule

`default_nettype wire

### sv/sfc_min_select.sv
`timescale 1ns / 1ps
`default_nettype none

module sfc_min_select (
    input  wire sfc_pkg::dist_t dists [sfc_pkg::PLANE_COUNT],
    output logic                visible,
    output sfc_pkg::min_dist_t  min_distance
);
    import sfc_pkg::*;

    dist_t m01;
    dist_t m23;
    dist_t m45;
    dist_t m0123;
    dist_t best;

    // three-level compare tree over the six plane sums
    assign m01   = (dists[1] < dists[0]) ? dists[1] : dists[0];
    assign m23   = (dists[3] < dists[2]) ? dists[3] : dists[2];
    assign m45   = (dists[5] < dists[4]) ? dists[5] : dists[4];
    assign m0123 = (m23 < m01) ? m23 : m01;
    assign best  = (m45 < m0123) ? m45 : m0123;

    // dropping the low fraction bits floors toward minus infinity
    assign min_distance = best[33:FRAC_ALIGN];
    assign visible      = ~best[33];

endmodule

`default_nettype wire

### sv/sphere_frustum_cull_top.sv
// Sphere versus frustum culler. Each word on the sphere channel is one bounding sphere
// (signed Q12.4 centre, unsigned Q11.4 radius); for each of the six planes held in the
// configuration registers (index 0..5: left, right, bottom, top, near, far; each
// nx/ny/nz Q1.14 and d Q12.4) the block forms the exact sum n.c + d + r and returns
// the least of the six, floored to Q16.4, plus a visible flag that is set when that
// least sum is not negative. The block takes one sphere per clock unless a stall holds
// it, and has three register stages: input register, per-plane sum register after the
// six multiply-add lanes, and the result register after the min tree. A stall on the
// result channel holds the full stages from the result register back to the first gap;
// an empty stage still loads, and the input takes a word while it or a stage ahead has
// room. Plane registers reset to a zero normal with d = +2047.9375, which never culls.
// Write the planes only while no sphere is in flight; indexes 6 and 7 are ignored.
`timescale 1ns / 1ps
`default_nettype none
`include "sphere_frustum_cull_top_assert.svh"

module sphere_frustum_cull_top (
    input  wire logic     clk,
    input  wire logic     rst_n,
    sfc_sphere_if.sink    sphere,
    sfc_result_if.source  result,
    sfc_cfg_if.sink       cfg
);
    import sfc_pkg::*;

    plane_t planes [PLANE_COUNT];

    // stage 1: input register
    logic      s1_vld_reg;
    logic      s1_vld_next;
    coord_t    cx_reg;
    coord_t    cy_reg;
    coord_t    cz_reg;
    radius_t   rad_reg;

    // stage 2: per-plane sums
    logic      s2_vld_reg;
    logic      s2_vld_next;
    dist_t     lane_dist [PLANE_COUNT];
    dist_t     dist_reg  [PLANE_COUNT];

    // stage 3: result register
    logic      s3_vld_reg;
    logic      s3_vld_next;
    logic      vis_comb;
    min_dist_t mind_comb;
    logic      vis_reg;
    min_dist_t mind_reg;

    logic      s3_adv;
    logic      s2_adv;
    logic      s1_adv;

    sfc_plane_regs u_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .planes (planes)
    );

    // One multiply-add lane per plane, all working on the same sphere.
    for (genvar g = 0; g < PLANE_COUNT; g++)
    begin : g_lane
        sfc_plane_lane u_lane (
            .plane         (planes[g]),
            .center_x      (cx_reg),
            .center_y      (cy_reg),
            .center_z      (cz_reg),
            .sphere_radius (rad_reg),
            .plane_sum     (lane_dist[g])
        );
    end

    sfc_min_select u_min (
        .dists        (dist_reg),
        .visible      (vis_comb),
        .min_distance (mind_comb)
    );

    // A stage loads when it is empty or when the stage ahead of it moves on.
    assign s3_adv = ~s3_vld_reg | result.ready;
    assign s2_adv = ~s2_vld_reg | s3_adv;
    assign s1_adv = ~s1_vld_reg | s2_adv;

    assign sphere.ready = s1_adv;

    assign s1_vld_next = s1_adv ? sphere.valid : s1_vld_reg;
    assign s2_vld_next = s2_adv ? s1_vld_reg   : s2_vld_reg;
    assign s3_vld_next = s3_adv ? s2_vld_reg   : s3_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= s1_vld_next;
            s2_vld_reg <= s2_vld_next;
            s3_vld_reg <= s3_vld_next;
        end
    end

    // Payload registers: load with their stage, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            cx_reg  <= sphere.center_x;
            cy_reg  <= sphere.center_y;
            cz_reg  <= sphere.center_z;
            rad_reg <= sphere.sphere_radius;
        end
        if (s2_adv)
        begin
            dist_reg <= lane_dist;
        end
        if (s3_adv)
        begin
            vis_reg  <= vis_comb;
            mind_reg <= mind_comb;
        end
    end

    assign result.valid        = s3_vld_reg;
    assign result.visible      = vis_reg;
    assign result.min_distance = mind_reg;

    // An accepted word always lands in the input register.
    `SFC_ASSERT_NEXT(a_accept_loads, clk, rst_n, sphere.valid && sphere.ready, s1_vld_reg)

    // A word in stage 1 with stage 2 empty moves on in the next cycle.
    `SFC_ASSERT_NEXT(a_s1_moves, clk, rst_n, s1_vld_reg && !s2_vld_reg, s2_vld_reg)

    // Flooring keeps the sign, so the flag agrees with the distance sign.
    `SFC_ASSERT_NOW(a_vis_sign, clk, rst_n, result.valid,
                    result.visible == !result.min_distance[19])

endmodule

`default_nettype wire
